// ===== src/base64_stream_encoder_defines.svh =====
// Assertion macros shared by the encoder modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTH

`define B64E_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define B64E_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define B64E_ASSERT_IMP(lbl, ante, cons)

`define B64E_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== src/b64e_pkg.sv =====
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR = 7'h3D;
    localparam logic [1:0] LAST_IDX = 2'd3;

    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } byte_word_t;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       group_end;
        logic       message_end;
    } char_word_t;

    // one 24-bit group on its way from the front to the back
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad;
        logic        fin;
    } grp_t;

    typedef struct packed {
        logic push;
        grp_t grp;
    } grp_push_t;

    function automatic logic [6:0] sym_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
            c = 7'h41 + {1'b0, v};
        else if (v < 6'd52)
            c = 7'h61 + {1'b0, v} - 7'd26;
        else if (v < 6'd62)
            c = 7'h30 + {1'b0, v} - 7'd52;
        else if (v == 6'd62)
            c = 7'h2B;
        else
            c = 7'h2F;
        return c;
    endfunction

endpackage

// ===== src/b64e_front.sv =====
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_word_t byte_data,
    input  logic       q_full,
    output grp_push_t  q_wr
);

    logic [15:0] pending_reg, pending_next;
    logic [1:0]  phase_reg, phase_next;
    logic        accept;
    logic        emit;
    logic [1:0]  phase;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;
    // phase three never occurs; treat it as an empty group
    assign phase      = (phase_reg == 2'd3) ? 2'd0 : phase_reg;
    assign emit       = (phase == 2'd2) || byte_data.final_byte;

    always_comb
    begin
        pending_next = pending_reg;
        phase_next   = phase_reg;
        q_wr.push    = accept && emit;
        q_wr.grp.fin = byte_data.final_byte;
        q_wr.grp.bits = {pending_reg, byte_data.data_byte};
        q_wr.grp.pad  = PAD_NONE;
        unique case (phase)
            2'd0:
            begin
                q_wr.grp.bits = {byte_data.data_byte, 16'h0000};
                q_wr.grp.pad  = PAD_TWO;
            end
            2'd1:
            begin
                q_wr.grp.bits = {pending_reg[15:8], byte_data.data_byte, 8'h00};
                q_wr.grp.pad  = PAD_ONE;
            end
            default:
            begin
                q_wr.grp.bits = {pending_reg, byte_data.data_byte};
                q_wr.grp.pad  = PAD_NONE;
            end
        endcase
        if (accept)
        begin
            if (emit)
            begin
                pending_next = 16'h0000;
                phase_next   = 2'd0;
            end
            else if (phase == 2'd0)
            begin
                pending_next = {byte_data.data_byte, 8'h00};
                phase_next   = 2'd1;
            end
            else
            begin
                pending_next = {pending_reg[15:8], byte_data.data_byte};
                phase_next   = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 16'h0000;
            phase_reg   <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

// ===== src/b64e_fifo.sv =====
`include "base64_stream_encoder_defines.svh"

module b64e_fifo
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  grp_push_t wr,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output grp_t      rd_grp
);

    grp_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_grp = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr.push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !wr.push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            mem[wr_ptr_reg] <= wr.grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B64E_ASSERT_IMP(a_no_overflow, wr.push, !full)
    `B64E_ASSERT_IMP(a_no_underflow, pop, !empty)
    `B64E_ASSERT_NXT(a_push_only_fills, wr.push && !pop, !empty)

endmodule

// ===== src/b64e_back.sv =====
`include "base64_stream_encoder_defines.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    output logic       q_pop,
    input  grp_t       q_grp,
    output logic       char_valid,
    input  logic       char_stall,
    output char_word_t char_data
);

    grp_t       grp_reg;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       last;
    logic       load;
    logic [5:0] sextet;
    logic       is_pad;

    assign last  = (idx_reg == LAST_IDX);
    assign load  = !q_empty && (!busy_reg || (last && !char_stall));
    assign q_pop = load;

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg && !char_stall)
        begin
            idx_next = idx_reg + 1'b1;
            if (last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= q_grp;
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = grp_reg.bits[23:18];
            2'd1:    sextet = grp_reg.bits[17:12];
            2'd2:    sextet = grp_reg.bits[11:6];
            default: sextet = grp_reg.bits[5:0];
        endcase
    end

    // trailing pad slots: char index counted from the end is below the pad count
    assign is_pad = ((~idx_reg) < grp_reg.pad);

    assign char_valid            = busy_reg;
    assign char_data.ascii_char  = is_pad ? PAD_CHAR : sym_char(sextet);
    assign char_data.group_end   = last;
    assign char_data.message_end = last && grp_reg.fin;

    `B64E_ASSERT_IMP(a_msg_end_on_group_end, char_valid && char_data.message_end,
                     char_data.group_end)
    `B64E_ASSERT_IMP(a_pad_only_at_tail, char_valid && is_pad, idx_reg[1])
    `B64E_ASSERT_NXT(a_stall_holds_char, char_valid && char_stall,
                     char_valid && $stable(idx_reg))

endmodule

// ===== src/base64_stream_encoder.sv =====
// Base64 encoder (standard alphabet, '=' padding) taking one byte per word and emitting one
// ASCII character per word. Bytes are grouped in threes; a completed group, or the byte
// flagged final_byte, queues a group that the output side spells out as four characters,
// one per cycle while char_stall is low, with group_end on the fourth and message_end on
// the fourth of the last group. Input bytes are taken every cycle while the two-entry group
// queue has room, so the sustained rate is set by the output side, which spells out four
// characters per group, be it three bytes or the lone byte of a one-byte message. A closed
// group passes through the group queue and the group register before its first character.
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_word_t byte_data,
    output logic       char_valid,
    input  logic       char_stall,
    output char_word_t char_data
);

    grp_push_t q_wr;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    grp_t      q_grp;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    b64e_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .full   (q_full),
        .empty  (q_empty),
        .pop    (q_pop),
        .rd_grp (q_grp)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_grp      (q_grp),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule
